/* rtl/dwv_pkg.sv */
// ----------------------------------------------------------------------------
// dwv_pkg
// Shared types and constants of the differential wheel velocity PID core.
// ----------------------------------------------------------------------------
package dwv_pkg;

    localparam int unsigned NUM_REGS = 8;
    localparam logic [2:0] REG_LEFT_P = 3'd0;
    localparam logic [2:0] REG_LEFT_I = 3'd1;
    localparam logic [2:0] REG_LEFT_D = 3'd2;
    localparam logic [2:0] REG_RIGHT_P = 3'd3;
    localparam logic [2:0] REG_RIGHT_I = 3'd4;
    localparam logic [2:0] REG_RIGHT_D = 3'd5;
    localparam logic [2:0] REG_LEFT_CIRC = 3'd6;
    localparam logic [2:0] REG_RIGHT_CIRC = 3'd7;

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_ENCODER = 1'b1;

    // PID phases of one wheel, in the order they run.
    localparam logic [2:0] PH_SPEED = 3'd0;
    localparam logic [2:0] PH_SIGN  = 3'd1;
    localparam logic [2:0] PH_ERR   = 3'd2;
    localparam logic [2:0] PH_INTEG = 3'd3;
    localparam logic [2:0] PH_DRIVE = 3'd4;

    localparam logic signed [20:0] INTEG_LIMIT = 21'sd652800;
    localparam logic [7:0] DRIVE_MAX = 8'd255;
    localparam logic [24:0] TIME_SCALE = 25'd16000000;
    localparam logic [15:0] LINEAR_SCALE = 16'd3200;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic load_cmd;    // compute goals from the command item
        logic load_enc;    // latch encoder item and deltas
        logic div_start;   // start the speed divider for the selected wheel
        logic mul_num;     // form the numerator of the selected wheel
        logic pid_step;    // run one PID phase for the selected wheel
        logic [2:0] phase; // PID phase
        logic wheel;       // 0 left, 1 right
        logic store_out;   // register the result item
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_status;

endpackage

/* rtl/dwv_div.sv */
// ----------------------------------------------------------------------------
// dwv_div
// Restoring divider, one quotient bit per cycle, for the wheel speed.
// ----------------------------------------------------------------------------
module dwv_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [55:0] i_num,
    input  logic [47:0] i_den,
    output logic        o_busy,
    output logic [55:0] o_quo
);
    logic [55:0] r_quo;
    logic [48:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [48:0] w_shift;
    logic [49:0] w_diff;

    assign w_shift = {r_rem[47:0], r_quo[55]};
    assign w_diff  = {1'b0, w_shift} - {2'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd55;
        end else if (r_busy) begin
            if (r_cnt == 6'd0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!w_diff[49]) begin
                r_rem <= w_diff[48:0];
                r_quo <= {r_quo[54:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[54:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

/* rtl/dwv_ctrl.sv */
// ----------------------------------------------------------------------------
// dwv_ctrl
// Sequencer of the core: accepts items, steps the datapath, holds the result.
// ----------------------------------------------------------------------------
module dwv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_kind,
    input  logic             i_out_ready,
    input  dwv_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output dwv_pkg::t_cmd    o_cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIVS = 3'd2;
    localparam logic [2:0] ST_DIVW = 3'd3;
    localparam logic [2:0] ST_PID  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_wheel, n_wheel;
    logic [2:0] r_phase, n_phase;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_wheel = r_wheel;
        n_phase = r_phase;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd = '0;
        o_cmd.wheel = r_wheel;
        o_cmd.phase = r_phase;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_kind == dwv_pkg::KIND_COMMAND) begin
                        o_cmd.load_cmd = 1'b1;
                    end else begin
                        o_cmd.load_enc = 1'b1;
                        n_state = ST_MUL;
                        n_wheel = 1'b0;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul_num = 1'b1;
                n_state = ST_DIVS;
            end
            ST_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIVW;
            end
            ST_DIVW: begin
                if (!i_status.div_busy) begin
                    n_state = ST_PID;
                    n_phase = dwv_pkg::PH_SPEED;
                end
            end
            ST_PID: begin
                o_cmd.pid_step = 1'b1;
                if (r_phase == dwv_pkg::PH_DRIVE) begin
                    if (r_wheel) begin
                        n_state = ST_DONE;
                    end else begin
                        n_wheel = 1'b1;
                        n_state = ST_MUL;
                    end
                end else begin
                    n_phase = r_phase + 3'd1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.store_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wheel <= 1'b0;
            r_phase <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wheel <= n_wheel;
            r_phase <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

/* rtl/dwv_dp.sv */
// ----------------------------------------------------------------------------
// dwv_dp
// Datapath: goals, count and time deltas, speed division and PID per wheel.
// ----------------------------------------------------------------------------
module dwv_dp #(
    parameter int unsigned COUNTS_PER_REV = 2031,
    parameter int unsigned WHEEL_BASE_SIXTEENTHS = 580
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dwv_pkg::t_cmd       i_cmd,
    output dwv_pkg::t_status    o_status,
    input  logic signed [15:0]  i_linear_speed,
    input  logic signed [15:0]  i_turn_rate,
    input  logic [15:0]         i_left_ticks,
    input  logic [15:0]         i_right_ticks,
    input  logic [31:0]         i_timestamp_us,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic [7:0]          o_left_drive,
    output logic [7:0]          o_right_drive,
    output logic                o_left_forward,
    output logic                o_right_forward,
    output logic signed [31:0]  o_left_speed,
    output logic signed [31:0]  o_right_speed
);
    localparam logic [15:0] CPR = 16'(COUNTS_PER_REV);
    localparam logic [15:0] WB  = 16'(WHEEL_BASE_SIXTEENTHS);

    logic [15:0] r_gain [6];
    logic [11:0] r_circ [2];
    logic signed [31:0] r_goal [2];
    logic [15:0] r_prev_cnt [2];
    logic [31:0] r_prev_ts;
    logic signed [20:0] r_integ [2];
    logic signed [31:0] r_last [2];
    logic signed [15:0] r_diff [2];
    logic [31:0] r_dt;
    logic [47:0] r_den;
    logic [55:0] r_num;
    logic        r_neg;
    logic signed [31:0] r_speed [2];
    logic signed [32:0] r_v, r_mag, r_err;
    logic signed [49:0] r_sum;
    logic [7:0]  r_drive [2];
    logic        r_fwd [2];
    logic [7:0]  r_o_drive [2];
    logic        r_o_fwd [2];
    logic signed [31:0] r_o_speed [2];

    logic        w_busy;
    logic [55:0] w_quo;
    logic        w;
    logic signed [31:0] w_goal, w_spd;
    logic [15:0] w_pg, w_ig, w_dg;
    logic signed [16:0] w_lin, w_rot_t;
    logic signed [33:0] w_base, w_rot, w_lg, w_rg;
    logic signed [33:0] w_acc;
    logic signed [20:0] w_accc;
    logic signed [33:0] w_dv;
    logic signed [31:0] w_sat;
    logic [31:0] w_ts_dt;
    logic [15:0] w_cnt_mag;

    assign w = i_cmd.wheel;

    dwv_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_num), .i_den(r_den), .o_busy(w_busy), .o_quo(w_quo)
    );
    assign o_status.div_busy = w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[0] <= 16'd1536; r_gain[1] <= 16'd128; r_gain[2] <= 16'd0;
            r_gain[3] <= 16'd1536; r_gain[4] <= 16'd128; r_gain[5] <= 16'd0;
            r_circ[0] <= 12'd752;  r_circ[1] <= 12'd752;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dwv_pkg::REG_LEFT_P:     r_gain[0] <= i_cfg_data;
                dwv_pkg::REG_LEFT_I:     r_gain[1] <= i_cfg_data;
                dwv_pkg::REG_LEFT_D:     r_gain[2] <= i_cfg_data;
                dwv_pkg::REG_RIGHT_P:    r_gain[3] <= i_cfg_data;
                dwv_pkg::REG_RIGHT_I:    r_gain[4] <= i_cfg_data;
                dwv_pkg::REG_RIGHT_D:    r_gain[5] <= i_cfg_data;
                dwv_pkg::REG_LEFT_CIRC:  r_circ[0] <= i_cfg_data[11:0];
                dwv_pkg::REG_RIGHT_CIRC: r_circ[1] <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign w_lin   = 17'(i_linear_speed);
    assign w_rot_t = 17'(i_turn_rate);
    assign w_base  = 34'(w_lin) * 34'($signed({1'b0, dwv_pkg::LINEAR_SCALE}));
    assign w_rot   = 34'(w_rot_t) * 34'($signed({1'b0, WB}));
    assign w_lg    = w_base - w_rot;
    assign w_rg    = w_base + w_rot;
    assign w_ts_dt = i_timestamp_us - r_prev_ts;

    assign w_goal = r_goal[w];
    assign w_spd  = r_speed[w];
    assign w_pg   = w ? r_gain[3] : r_gain[0];
    assign w_ig   = w ? r_gain[4] : r_gain[1];
    assign w_dg   = w ? r_gain[5] : r_gain[2];
    assign w_acc  = 34'(r_integ[w]) + 34'(r_err);
    assign w_accc = (w_acc > 34'(dwv_pkg::INTEG_LIMIT)) ? dwv_pkg::INTEG_LIMIT :
                    (w_acc < -34'(dwv_pkg::INTEG_LIMIT)) ? -dwv_pkg::INTEG_LIMIT :
                    w_acc[20:0];
    assign w_dv   = 34'(r_last[w]) - 34'(r_v);
    assign w_sat  = (w_quo[55:31] != 25'd0) ? 32'sh7FFFFFFF : $signed(w_quo[31:0]);
    assign w_cnt_mag = r_diff[w][15] ? 16'(-r_diff[w]) : 16'(r_diff[w]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal[0] <= '0; r_goal[1] <= '0;
            r_prev_cnt[0] <= '0; r_prev_cnt[1] <= '0;
            r_prev_ts <= '0;
            r_integ[0] <= '0; r_integ[1] <= '0;
            r_last[0] <= '0; r_last[1] <= '0;
        end else begin
            if (i_cmd.load_cmd) begin
                r_goal[0] <= 32'(w_lg >>> 5);
                r_goal[1] <= 32'(w_rg >>> 5);
            end
            if (i_cmd.load_enc) begin
                r_diff[0] <= $signed(i_left_ticks - r_prev_cnt[0]);
                r_diff[1] <= $signed(i_right_ticks - r_prev_cnt[1]);
                r_dt <= w_ts_dt;
                r_den <= 48'(CPR) * 48'(w_ts_dt);
                r_prev_cnt[0] <= i_left_ticks;
                r_prev_cnt[1] <= i_right_ticks;
                r_prev_ts <= i_timestamp_us;
            end
            if (i_cmd.mul_num) begin
                r_neg <= r_diff[w][15];
                r_num <= 56'({12'd0, w_cnt_mag} * {16'd0, r_circ[w]})
                         * 56'(dwv_pkg::TIME_SCALE);
            end
            if (i_cmd.pid_step) begin
                case (i_cmd.phase)
                    dwv_pkg::PH_SPEED: begin
                        if (r_dt == 32'd0) begin
                            r_speed[w] <= '0;
                        end else if (r_neg) begin
                            r_speed[w] <= (w_quo[55:32] != 24'd0 || w_quo[31:0] > 32'h80000000)
                                          ? 32'sh80000000 : 32'(-$signed({1'b0, w_quo[31:0]}));
                        end else begin
                            r_speed[w] <= w_sat;
                        end
                    end
                    dwv_pkg::PH_SIGN: begin
                        r_fwd[w] <= !w_goal[31];
                        r_mag <= w_goal[31] ? -33'(w_goal) : 33'(w_goal);
                        r_v <= w_goal[31] ? ((w_spd == 32'sh80000000) ? 33'sh7FFFFFFF
                                              : -33'(w_spd)) : 33'(w_spd);
                    end
                    dwv_pkg::PH_ERR: begin
                        r_err <= r_mag - r_v;
                    end
                    dwv_pkg::PH_INTEG: begin
                        r_integ[w] <= w_accc;
                        r_last[w] <= r_v[31:0];
                        r_sum <= 50'(r_err) * 50'($signed({1'b0, w_pg}))
                               + 50'(w_accc) * 50'($signed({1'b0, w_ig}))
                               + 50'(w_dv) * 50'($signed({1'b0, w_dg}));
                    end
                    dwv_pkg::PH_DRIVE: begin
                        if (r_sum <= 0 || r_mag == 0) begin
                            r_drive[w] <= '0;
                        end else if (r_sum[49:16] > 34'sd255) begin
                            r_drive[w] <= dwv_pkg::DRIVE_MAX;
                        end else begin
                            r_drive[w] <= r_sum[23:16];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_out) begin
            r_o_drive[0] <= r_drive[0]; r_o_drive[1] <= r_drive[1];
            r_o_fwd[0] <= r_fwd[0];     r_o_fwd[1] <= r_fwd[1];
            r_o_speed[0] <= r_speed[0]; r_o_speed[1] <= r_speed[1];
        end
    end

    assign o_left_drive    = r_o_drive[0];
    assign o_right_drive   = r_o_drive[1];
    assign o_left_forward  = r_o_fwd[0];
    assign o_right_forward = r_o_fwd[1];
    assign o_left_speed    = r_o_speed[0];
    assign o_right_speed   = r_o_speed[1];
endmodule

/* rtl/differential_wheel_velocity_pid_core.sv */
// ----------------------------------------------------------------------------
// differential_wheel_velocity_pid_core
// Two-wheel velocity PID controller for a differential drive.
// ----------------------------------------------------------------------------
// The slave channel takes command items (tuser 0) that set both wheel goals
// when accepted and give no result, and encoder items (tuser 1) that give one
// result item on the master channel with both drives, directions and speeds.
// For an encoder item, each wheel goes through the numerator multiply, the
// divider start, a 56-step bit-serial speed division and a five-step PID
// sequence; the wheels are done one after the other. The slave side is ready
// only while the block is idle. A finished result sits in an output register
// until taken; when the master side stalls, the next encoder item is still
// accepted and computed, then waits in its last step with the slave side not
// ready until the older result is taken. Configuration registers are to be
// written by the user through the plain write port only while the block is
// idle; the block does not enforce this. Synchronous active-low reset
// restores gains and circumferences, clears goals, integrals, previous
// samples and the output valid.
// ----------------------------------------------------------------------------
module differential_wheel_velocity_pid_core #(
    parameter int unsigned COUNTS_PER_REV = 2031,
    parameter int unsigned WHEEL_BASE_SIXTEENTHS = 580
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // linear_speed, turn_rate, left encoder ticks, right encoder ticks,
    // timestamp_us
    input  logic [95:0] s_axis_tdata,
    // kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // left_drive, right_drive, left_forward, right_forward, left_speed,
    // right_speed, zero fill
    output logic [87:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    dwv_pkg::t_cmd    w_cmd;
    dwv_pkg::t_status w_status;
    logic [7:0]  w_ld, w_rd;
    logic        w_lf, w_rf;
    logic [31:0] w_ls, w_rs;

    dwv_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_kind(s_axis_tuser),
        .i_out_ready(m_axis_tready), .i_status(w_status),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid), .o_cmd(w_cmd)
    );

    dwv_dp #(
        .COUNTS_PER_REV(COUNTS_PER_REV),
        .WHEEL_BASE_SIXTEENTHS(WHEEL_BASE_SIXTEENTHS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_linear_speed(s_axis_tdata[15:0]), .i_turn_rate(s_axis_tdata[31:16]),
        .i_left_ticks(s_axis_tdata[47:32]), .i_right_ticks(s_axis_tdata[63:48]),
        .i_timestamp_us(s_axis_tdata[95:64]),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_left_drive(w_ld), .o_right_drive(w_rd),
        .o_left_forward(w_lf), .o_right_forward(w_rf),
        .o_left_speed(w_ls), .o_right_speed(w_rs)
    );

    assign m_axis_tdata = {6'd0, w_rs, w_ls, w_rf, w_lf, w_rd, w_ld};

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.pid_step || w_status.div_busy) |-> !s_axis_tready)
        else $error("item accepted while busy");
    a_cmd_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid)
        |=> !m_axis_tvalid)
        else $error("command item produced a result");
    a_store_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.store_out |=> m_axis_tvalid)
        else $error("result not presented");
`endif
endmodule
